// ----- sv/motor_duty_ramp_watchdog_assert.svh -----
// Assertion macros used by the motor duty controller back end.
`ifndef MOTOR_DUTY_RAMP_WATCHDOG_ASSERT_SVH
`define MOTOR_DUTY_RAMP_WATCHDOG_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MDRW_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("mdrw: assertion failed");
// Check that a condition in one cycle brings a consequence in the next.
`define MDRW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mdrw: assertion failed");
`else
`define MDRW_ASSERT(label, prop)
`define MDRW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/mdrw_pkg.sv -----
// Types, constants and helper functions of the motor duty controller.
package mdrw_pkg;

   localparam int TIME_BITS = 32;
   localparam int LANES     = 2;
   localparam int CSR_IDX_W = 3;

   typedef logic [TIME_BITS-1:0] time_type;

   typedef enum logic [2:0] {
      OP_TICK, OP_HELLO, OP_SAFE, OP_STOP, OP_RUN, OP_TARGET, OP_HEARTBEAT, OP_READ
   } op_type;

   typedef enum logic [1:0] {MODE_STOP, MODE_SAFE, MODE_RUN} mode_type;

   typedef enum logic [1:0] {DIR_NONE, DIR_POS, DIR_NEG} dir_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCHDOG_MS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_INTERVAL_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_BRAKE_MS = 3'd4;

   // Channel field value that run expects (enable mask of channel 0)
   localparam logic [7:0] RUN_CHANNEL_MASK = 8'd1;
   localparam logic [1:0] ENABLE_RUN       = 2'b01;

   typedef struct packed {
      logic [14:0] max_duty;
      logic [14:0] ramp_step;
      logic [31:0] watchdog_ms;
      logic [31:0] ramp_interval_ms;
      logic [31:0] reverse_brake_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      max_duty:         15'd1000,
      ramp_step:        15'd10,
      watchdog_ms:      32'd500,
      ramp_interval_ms: 32'd10,
      reverse_brake_ms: 32'd100
   };

   // Classified command handed from the front end to the back end
   typedef struct packed {
      op_type             op;
      logic               plain_ok;
      logic               run_ok;
      logic               target_ok;
      logic signed [15:0] duty;
      time_type           now;
   } cmd_type;

   typedef struct packed {
      logic               accepted;
      logic signed [15:0] drive_a;
      logic signed [15:0] drive_b;
      mode_type           run_mode;
      logic               is_ready;
      logic               watchdog_expired;
   } rsp_type;

   // Command queue geometry
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
   typedef logic [CMDQ_PTR_W-1:0] cmdq_ptr_type;
   typedef logic [CMDQ_CNT_W-1:0] cmdq_cnt_type;
   localparam cmdq_ptr_type CMDQ_PTR_LAST = CMDQ_PTR_W'(CMDQ_DEPTH - 1);
   localparam cmdq_cnt_type CMDQ_FULL     = CMDQ_CNT_W'(CMDQ_DEPTH);

   // Result queue geometry
   localparam int RSPQ_DEPTH = 2;
   localparam int RSPQ_PTR_W = (RSPQ_DEPTH > 1) ? $clog2(RSPQ_DEPTH) : 1;
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);
   typedef logic [RSPQ_PTR_W-1:0] rspq_ptr_type;
   typedef logic [RSPQ_CNT_W-1:0] rspq_cnt_type;
   localparam rspq_ptr_type RSPQ_PTR_LAST = RSPQ_PTR_W'(RSPQ_DEPTH - 1);
   localparam rspq_cnt_type RSPQ_FULL     = RSPQ_CNT_W'(RSPQ_DEPTH);

   // Wrapping time difference
   function automatic time_type elapsed(input time_type now, input time_type then);
      return now - then;
   endfunction

endpackage

// ----- sv/mdrw_csr.sv -----
// Configuration registers of the motor duty controller.
module mdrw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mdrw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_data,
   output mdrw_pkg::cfg_type                cfg
);

   mdrw_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mdrw_pkg::CSR_MAX_DUTY:         cfg_in.max_duty         = csr_data[14:0];
            mdrw_pkg::CSR_RAMP_STEP:        cfg_in.ramp_step        = csr_data[14:0];
            mdrw_pkg::CSR_WATCHDOG_MS:      cfg_in.watchdog_ms      = csr_data;
            mdrw_pkg::CSR_RAMP_INTERVAL_MS: cfg_in.ramp_interval_ms = csr_data;
            mdrw_pkg::CSR_REVERSE_BRAKE_MS: cfg_in.reverse_brake_ms = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= mdrw_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/mdrw_front.sv -----
// Front end: decode and check the argument fields of an incoming command.
module mdrw_front (
   input  logic [2:0]           req_operation,
   input  logic [7:0]           req_channel,
   input  logic signed [15:0]   req_duty,
   input  logic [31:0]          req_now_ms,
   input  logic [14:0]          max_duty,
   output mdrw_pkg::cmd_type    cmd
);

   logic        duty_zero;
   logic        chan_zero;
   logic [15:0] duty_mag;

   assign duty_zero = (req_duty == 16'sd0);
   assign chan_zero = (req_channel == 8'd0);
   // most negative duty maps to 0x8000 and so never passes the limit
   assign duty_mag  = req_duty[15] ? 16'(-req_duty) : 16'(req_duty);

   always_comb begin
      cmd.op        = mdrw_pkg::op_type'(req_operation);
      cmd.plain_ok  = chan_zero && duty_zero;
      cmd.run_ok    = (req_channel == mdrw_pkg::RUN_CHANNEL_MASK) && duty_zero;
      cmd.target_ok = chan_zero && (duty_mag <= {1'b0, max_duty});
      cmd.duty      = req_duty;
      cmd.now       = req_now_ms[mdrw_pkg::TIME_BITS-1:0];
   end

endmodule

// ----- sv/mdrw_cmd_queue.sv -----
// Short queue of classified commands between the front and back ends.
module mdrw_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  mdrw_pkg::cmd_type    din,
   input  logic                 pop,
   output logic                 empty,
   output mdrw_pkg::cmd_type    dout
);

   mdrw_pkg::cmd_type     entry_ff [mdrw_pkg::CMDQ_DEPTH];
   mdrw_pkg::cmdq_ptr_type wr_ptr_ff, wr_ptr_in;
   mdrw_pkg::cmdq_ptr_type rd_ptr_ff, rd_ptr_in;
   mdrw_pkg::cmdq_cnt_type count_ff, count_in;
   logic push_fire, pop_fire;

   assign full      = (count_ff == mdrw_pkg::CMDQ_FULL);
   assign empty     = (count_ff == '0);
   assign dout      = entry_ff[rd_ptr_ff];
   assign push_fire = push && !full;
   assign pop_fire  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == mdrw_pkg::CMDQ_PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == mdrw_pkg::CMDQ_PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- sv/mdrw_back.sv -----
// Back end: tick (watchdog, ramp, brake), command execution and result queue.
`include "motor_duty_ramp_watchdog_assert.svh"
module mdrw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mdrw_pkg::cfg_type    cfg,
   input  mdrw_pkg::cmd_type    cmd,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output mdrw_pkg::rsp_type    rsp
);

   // controller state
   mdrw_pkg::mode_type   mode_ff, mode_in;
   logic                 ready_ff, ready_in;
   logic                 expired_ff, expired_in;
   logic [1:0]           enable_ff, enable_in;
   logic [1:0]           configured_ff, configured_in;
   logic signed [15:0]   target_ff [mdrw_pkg::LANES];
   logic signed [15:0]   target_in [mdrw_pkg::LANES];
   logic signed [15:0]   output_ff [mdrw_pkg::LANES];
   logic signed [15:0]   output_in [mdrw_pkg::LANES];
   mdrw_pkg::dir_type    dir_ff [mdrw_pkg::LANES];
   mdrw_pkg::dir_type    dir_in [mdrw_pkg::LANES];
   mdrw_pkg::time_type   zero_time_ff [mdrw_pkg::LANES];
   mdrw_pkg::time_type   zero_time_in [mdrw_pkg::LANES];
   mdrw_pkg::time_type   contact_ff, contact_in;
   mdrw_pkg::time_type   step_ff, step_in;

   // after the watchdog check
   logic                 wd_fire;
   mdrw_pkg::mode_type   mode_tk;
   logic                 ready_tk, expired_tk;
   logic [1:0]           enable_tk, configured_tk;
   logic signed [15:0]   target_tk [mdrw_pkg::LANES];
   logic signed [15:0]   output_tk [mdrw_pkg::LANES];
   mdrw_pkg::time_type   zero_time_tk [mdrw_pkg::LANES];

   // after the ramp step
   logic                 ramp_due;
   logic signed [16:0]   step_s;
   logic signed [16:0]   wanted_w [mdrw_pkg::LANES];
   logic signed [16:0]   cur_w [mdrw_pkg::LANES];
   logic signed [16:0]   up_w [mdrw_pkg::LANES];
   logic signed [16:0]   dn_w [mdrw_pkg::LANES];
   logic signed [16:0]   nxt_w [mdrw_pkg::LANES];
   mdrw_pkg::dir_type    want_dir [mdrw_pkg::LANES];
   logic signed [15:0]   output_rp [mdrw_pkg::LANES];
   mdrw_pkg::dir_type    dir_rp [mdrw_pkg::LANES];
   mdrw_pkg::time_type   zero_time_rp [mdrw_pkg::LANES];
   mdrw_pkg::time_type   step_rp;

   logic                 exec;
   logic                 accept;

   // result queue
   mdrw_pkg::rsp_type      rq_ff [mdrw_pkg::RSPQ_DEPTH];
   mdrw_pkg::rsp_type      rq_din;
   mdrw_pkg::rspq_ptr_type rq_wr_ff, rq_wr_in;
   mdrw_pkg::rspq_ptr_type rq_rd_ff, rq_rd_in;
   mdrw_pkg::rspq_cnt_type rq_count_ff, rq_count_in;
   logic                   rq_pop_fire;

   assign rsp_empty   = (rq_count_ff == '0);
   assign rsp         = rq_ff[rq_rd_ff];
   assign rq_pop_fire = rsp_pop && !rsp_empty;
   assign exec        = cmd_valid && ((rq_count_ff != mdrw_pkg::RSPQ_FULL) || rq_pop_fire);
   assign cmd_pop     = exec;
   assign step_s      = $signed({2'b00, cfg.ramp_step});

   // watchdog: contact lapsed in run mode forces stop
   always_comb begin
      wd_fire = (mode_ff == mdrw_pkg::MODE_RUN) &&
                (32'(mdrw_pkg::elapsed(cmd.now, contact_ff)) > cfg.watchdog_ms);
      mode_tk       = mode_ff;
      ready_tk      = ready_ff;
      expired_tk    = expired_ff;
      enable_tk     = enable_ff;
      configured_tk = configured_ff;
      for (int i = 0; i < mdrw_pkg::LANES; i++) begin
         target_tk[i]    = target_ff[i];
         output_tk[i]    = output_ff[i];
         zero_time_tk[i] = zero_time_ff[i];
      end
      if (wd_fire) begin
         mode_tk       = mdrw_pkg::MODE_STOP;
         ready_tk      = 1'b0;
         expired_tk    = 1'b1;
         enable_tk     = '0;
         configured_tk = '0;
         for (int i = 0; i < mdrw_pkg::LANES; i++) begin
            target_tk[i]    = 16'sd0;
            output_tk[i]    = 16'sd0;
            zero_time_tk[i] = cmd.now;
         end
      end
      ramp_due = 32'(mdrw_pkg::elapsed(cmd.now, step_ff)) >= cfg.ramp_interval_ms;
      step_rp  = ramp_due ? cmd.now : step_ff;
   end

   // ramp each lane toward its wanted duty, holding at zero before a reversal
   always_comb begin
      for (int i = 0; i < mdrw_pkg::LANES; i++) begin
         wanted_w[i] = (mode_tk == mdrw_pkg::MODE_RUN && enable_tk[i]) ?
                       {target_tk[i][15], target_tk[i]} : 17'sd0;
         want_dir[i] = (wanted_w[i] > 17'sd0) ? mdrw_pkg::DIR_POS :
                       ((wanted_w[i] < 17'sd0) ? mdrw_pkg::DIR_NEG : mdrw_pkg::DIR_NONE);
         if (want_dir[i] != mdrw_pkg::DIR_NONE && dir_ff[i] != mdrw_pkg::DIR_NONE &&
             want_dir[i] != dir_ff[i]) begin
            if (output_tk[i] != 16'sd0 ||
                32'(mdrw_pkg::elapsed(cmd.now, zero_time_tk[i])) < cfg.reverse_brake_ms) begin
               wanted_w[i] = 17'sd0;
            end
         end
         cur_w[i] = {output_tk[i][15], output_tk[i]};
         up_w[i]  = cur_w[i] + step_s;
         dn_w[i]  = cur_w[i] - step_s;
         nxt_w[i] = cur_w[i];
         if (cur_w[i] < wanted_w[i]) begin
            nxt_w[i] = (up_w[i] > wanted_w[i]) ? wanted_w[i] : up_w[i];
         end else if (cur_w[i] > wanted_w[i]) begin
            nxt_w[i] = (dn_w[i] < wanted_w[i]) ? wanted_w[i] : dn_w[i];
         end
         output_rp[i]    = output_tk[i];
         dir_rp[i]       = dir_ff[i];
         zero_time_rp[i] = zero_time_tk[i];
         if (ramp_due) begin
            output_rp[i] = nxt_w[i][15:0];
            if (nxt_w[i] != 17'sd0) begin
               dir_rp[i] = (nxt_w[i] > 17'sd0) ? mdrw_pkg::DIR_POS : mdrw_pkg::DIR_NEG;
            end
            if (cur_w[i] != 17'sd0 && nxt_w[i] == 17'sd0) begin
               zero_time_rp[i] = cmd.now;
            end
            if (mode_tk != mdrw_pkg::MODE_RUN) begin
               zero_time_rp[i] = cmd.now;
            end
         end
      end
   end

   // apply the command on top of the ticked state
   always_comb begin
      accept        = 1'b0;
      mode_in       = mode_tk;
      ready_in      = ready_tk;
      expired_in    = expired_tk;
      enable_in     = enable_tk;
      configured_in = configured_tk;
      contact_in    = contact_ff;
      step_in       = step_rp;
      for (int i = 0; i < mdrw_pkg::LANES; i++) begin
         target_in[i]    = target_tk[i];
         output_in[i]    = output_rp[i];
         dir_in[i]       = dir_rp[i];
         zero_time_in[i] = zero_time_rp[i];
      end
      unique case (cmd.op)
         mdrw_pkg::OP_TICK: begin
            accept = 1'b1;
         end
         mdrw_pkg::OP_HELLO: begin
            if (cmd.plain_ok) begin
               accept   = 1'b1;
               ready_in = 1'b1;
            end
         end
         mdrw_pkg::OP_SAFE, mdrw_pkg::OP_STOP: begin
            if (cmd.plain_ok) begin
               accept        = 1'b1;
               mode_in       = (cmd.op == mdrw_pkg::OP_SAFE) ?
                               mdrw_pkg::MODE_SAFE : mdrw_pkg::MODE_STOP;
               enable_in     = '0;
               configured_in = '0;
               for (int i = 0; i < mdrw_pkg::LANES; i++) begin
                  target_in[i]    = 16'sd0;
                  output_in[i]    = 16'sd0;
                  zero_time_in[i] = cmd.now;
               end
            end
         end
         mdrw_pkg::OP_RUN: begin
            if (cmd.run_ok && ready_tk && configured_tk[0]) begin
               accept     = 1'b1;
               enable_in  = mdrw_pkg::ENABLE_RUN;
               mode_in    = mdrw_pkg::MODE_RUN;
               expired_in = 1'b0;
               contact_in = cmd.now;
               step_in    = cmd.now;
            end
         end
         mdrw_pkg::OP_TARGET: begin
            if (cmd.target_ok) begin
               accept           = 1'b1;
               target_in[0]     = cmd.duty;
               configured_in[0] = 1'b1;
               contact_in       = cmd.now;
            end
         end
         mdrw_pkg::OP_HEARTBEAT: begin
            if (cmd.plain_ok) begin
               accept     = 1'b1;
               contact_in = cmd.now;
            end
         end
         mdrw_pkg::OP_READ: begin
            accept = cmd.plain_ok;
         end
      endcase
      rq_din.accepted         = accept;
      rq_din.drive_a          = output_in[0];
      rq_din.drive_b          = output_in[1];
      rq_din.run_mode         = mode_in;
      rq_din.is_ready         = ready_in;
      rq_din.watchdog_expired = expired_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mdrw_pkg::MODE_STOP;
         ready_ff      <= 1'b0;
         expired_ff    <= 1'b0;
         enable_ff     <= '0;
         configured_ff <= '0;
         contact_ff    <= '0;
         step_ff       <= '0;
         for (int i = 0; i < mdrw_pkg::LANES; i++) begin
            target_ff[i]    <= 16'sd0;
            output_ff[i]    <= 16'sd0;
            dir_ff[i]       <= mdrw_pkg::DIR_NONE;
            zero_time_ff[i] <= '0;
         end
      end else if (exec) begin
         mode_ff       <= mode_in;
         ready_ff      <= ready_in;
         expired_ff    <= expired_in;
         enable_ff     <= enable_in;
         configured_ff <= configured_in;
         contact_ff    <= contact_in;
         step_ff       <= step_in;
         for (int i = 0; i < mdrw_pkg::LANES; i++) begin
            target_ff[i]    <= target_in[i];
            output_ff[i]    <= output_in[i];
            dir_ff[i]       <= dir_in[i];
            zero_time_ff[i] <= zero_time_in[i];
         end
      end
   end

   // result queue pointers
   always_comb begin
      rq_wr_in = rq_wr_ff;
      rq_rd_in = rq_rd_ff;
      if (exec) begin
         rq_wr_in = (rq_wr_ff == mdrw_pkg::RSPQ_PTR_LAST) ? '0 : rq_wr_ff + 1'b1;
      end
      if (rq_pop_fire) begin
         rq_rd_in = (rq_rd_ff == mdrw_pkg::RSPQ_PTR_LAST) ? '0 : rq_rd_ff + 1'b1;
      end
      priority if (exec && !rq_pop_fire) begin
         rq_count_in = rq_count_ff + 1'b1;
      end else if (rq_pop_fire && !exec) begin
         rq_count_in = rq_count_ff - 1'b1;
      end else begin
         rq_count_in = rq_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rq_ff[rq_wr_ff] <= rq_din;
      end
   end

   `MDRW_ASSERT(a_chan1_never_driven, output_ff[1] == 16'sd0)
   `MDRW_ASSERT(a_expired_not_run, expired_ff |-> (mode_ff != mdrw_pkg::MODE_RUN))
   `MDRW_ASSERT(a_run_is_armed, (mode_ff == mdrw_pkg::MODE_RUN) |-> (configured_ff[0] && enable_ff == mdrw_pkg::ENABLE_RUN))
   `MDRW_ASSERT_NEXT(a_target_configures, exec && cmd.op == mdrw_pkg::OP_TARGET && cmd.target_ok, configured_ff[0])

endmodule

// ----- sv/motor_duty_ramp_watchdog.sv -----
// Top level of the two-channel motor duty controller with ramp and watchdog.
// A command is registered in the command queue, then executed by the back end, whose result
// is registered in the result queue and driven on the rsp_ ports from its head.
// Throughput: one item per cycle while the result queue has room or is popped; the execute
// stage updates all state together, so back-to-back items see each other's effects.
// Reset (synchronous, active high) restores the register defaults, stop mode and empty queues.
module motor_duty_ramp_watchdog (
   input  logic                            clock,
   input  logic                            reset,

   // command channel
   input  logic                            push,
   output logic                            full,
   input  logic [2:0]                      req_operation,
   input  logic [7:0]                      req_channel,
   input  logic signed [15:0]              req_duty,
   input  logic [31:0]                     req_now_ms,

   // result channel
   output logic                            empty,
   input  logic                            pop,
   output logic                            rsp_accepted,
   output logic signed [15:0]              rsp_drive_a,
   output logic signed [15:0]              rsp_drive_b,
   output logic [1:0]                      rsp_run_mode,
   output logic                            rsp_is_ready,
   output logic                            rsp_watchdog_expired,

   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mdrw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data
);

   mdrw_pkg::cfg_type cfg;
   mdrw_pkg::cmd_type cmd_front;
   mdrw_pkg::cmd_type cmd_back;
   mdrw_pkg::rsp_type rsp;
   logic              cmdq_empty;
   logic              cmdq_pop;

   // Register file, always ready; the source must write it only while no command is in flight (not enforced here).
   mdrw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Front end: classify the argument fields so the back end only checks state.
   mdrw_front u_front (
      .req_operation (req_operation),
      .req_channel   (req_channel),
      .req_duty      (req_duty),
      .req_now_ms    (req_now_ms),
      .max_duty      (cfg.max_duty),
      .cmd           (cmd_front)
   );

   // Decouple front from back; full once two commands wait on a stalled back end.
   mdrw_cmd_queue u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .din   (cmd_front),
      .pop   (cmdq_pop),
      .empty (cmdq_empty),
      .dout  (cmd_back)
   );

   // Back end: tick, execute, and hold results until the consumer takes them.
   mdrw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd_back),
      .cmd_valid (!cmdq_empty),
      .cmd_pop   (cmdq_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp       (rsp)
   );

   // Drive the result ports from the head of the result queue.
   assign rsp_accepted         = rsp.accepted;
   assign rsp_drive_a          = rsp.drive_a;
   assign rsp_drive_b          = rsp.drive_b;
   assign rsp_run_mode         = rsp.run_mode;
   assign rsp_is_ready         = rsp.is_ready;
   assign rsp_watchdog_expired = rsp.watchdog_expired;

endmodule
